>>> design/collision_time_tracker_unit_defines.svh
// Assertion macros for the checker file of the collision time tracker
`ifndef COLLISION_TIME_TRACKER_UNIT_DEFINES_SVH
`define COLLISION_TIME_TRACKER_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define CTT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define CTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ctt_pkg.sv
// Shared types and constants of the collision time tracker
package ctt_pkg;

  localparam int WinDepth = 16;
  localparam int SlotW    = 4;
  localparam int FillW    = 5;
  localparam int DivNW    = 48;
  localparam int DivDW    = 24;

  localparam logic [19:0] US_PER_S    = 20'd1000000;
  localparam logic [13:0] TTC_MAX     = 14'd15360;
  localparam logic [11:0] FOLLOW_NUM  = 12'd3840;
  localparam logic [4:0]  MPH_TO_FTS  = 5'd22;
  localparam logic [4:0]  WIN_RESET   = 5'd8;
  localparam logic [4:0]  WIN_MIN     = 5'd2;
  localparam logic [4:0]  WIN_MAX     = 5'd16;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_VEL, OP_ACC, OP_WRITE, OP_SUM, OP_MD, OP_MV,
    OP_MA, OP_PROD, OP_DISC, OP_SQRT, OP_TTC, OP_FOLLOW, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREV, S_VEL, S_VEL_W, S_ACC, S_ACC_W, S_WRITE, S_SUM, S_SUM_W,
    S_MD, S_MD_W, S_MV, S_MV_W, S_MA, S_MA_W, S_PROD, S_DISC, S_SQRT,
    S_SQRT_W, S_TTC, S_TTC_W, S_FOL, S_FOL_W, S_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic sum_busy;
    logic out_full;
  } status_t;

endpackage

>>> design/ctt_div.sv
// Restoring divider, one quotient bit per cycle
module ctt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ctt_pkg::DivNW-1:0]   num,
  input  logic [ctt_pkg::DivDW-1:0]   den,
  output logic                        busy,
  output logic [ctt_pkg::DivNW-1:0]   quo
);

  logic [ctt_pkg::DivDW-1:0] rem;
  logic [ctt_pkg::DivDW-1:0] den_r;
  logic [5:0]                cnt;
  logic [ctt_pkg::DivDW:0]   rem_sh;
  logic [ctt_pkg::DivDW:0]   diff;
  logic                      ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, quo[ctt_pkg::DivNW-1]};
    ge     = rem_sh >= {1'b0, den_r};
    diff   = rem_sh - {1'b0, den_r};
  end

  // Hold the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 6'(ctt_pkg::DivNW - 1)) begin
      busy <= 1'b0;
    end
  end

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[ctt_pkg::DivDW-1:0] : rem_sh[ctt_pkg::DivDW-1:0];
      quo <= {quo[ctt_pkg::DivNW-2:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

>>> design/ctt_sqrt.sv
// Integer square root, two radicand bits per cycle
module ctt_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] rad,
  output logic        busy,
  output logic [23:0] root
);

  logic [47:0] x;
  logic [47:0] r;
  logic [47:0] b;
  logic [4:0]  cnt;
  logic [47:0] trial;

  assign trial = r + b;
  assign root  = r[23:0];

  // Hold the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd23) begin
      busy <= 1'b0;
    end
  end

  // Advance one root bit
  always_ff @(posedge clk) begin
    if (start) begin
      x   <= rad;
      r   <= '0;
      b   <= 48'h4000_0000_0000;
      cnt <= '0;
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b   <= b >> 2;
      cnt <= cnt + 5'd1;
    end
  end

endmodule

>>> design/ctt_dp.sv
// Datapath: window rings, sums, shared divider and root unit, output register
module ctt_dp (
  input  logic             clk,
  input  logic             rst,
  input  ctt_pkg::cmd_t    cmd,
  output ctt_pkg::status_t status,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  input  logic [55:0]      in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [95:0]      out_data
);

  // Window rings with valid bits
  logic [15:0]        ring_d [ctt_pkg::WinDepth];
  logic signed [23:0] ring_v [ctt_pkg::WinDepth];
  logic signed [23:0] ring_a [ctt_pkg::WinDepth];
  logic [ctt_pkg::WinDepth-1:0] ring_ok;
  logic [15:0]        rd_d;
  logic signed [23:0] rd_v;
  logic [ctt_pkg::SlotW-1:0] ra;

  logic [ctt_pkg::SlotW-1:0] slot;
  logic [ctt_pkg::FillW-1:0] fill;
  logic [ctt_pkg::FillW-1:0] fill_inc;
  logic [4:0]                winlen;
  logic [4:0]                win_eff;

  logic [15:0] din;
  logic [15:0] spd;
  logic [19:0] iv;

  logic signed [23:0] vnew, anew, mv, ma;
  logic [15:0]        md;
  logic [19:0]        sd;
  logic signed [27:0] sv, sa;
  logic [4:0]         sum_k;
  logic               sum_busy, sum_acc;
  logic signed [47:0] p1;
  logic signed [40:0] p2;
  logic signed [48:0] disc;
  logic               tt_ok;
  logic [13:0]        ttc;
  logic [15:0]        ftime;

  // Divider and root unit hookup
  logic                      div_start, div_busy, div_pend, div_neg, div_neg_r;
  logic [ctt_pkg::DivNW-1:0] div_num, div_quo;
  logic [ctt_pkg::DivDW-1:0] div_den;
  ctt_pkg::op_t              div_op;
  logic                      sqrt_start, sqrt_busy;
  logic [23:0]               sqrt_root;

  logic signed [16:0] dv;
  logic [16:0]        dv_mag;
  logic [36:0]        dv_prod;
  logic signed [24:0] da;
  logic [24:0]        da_mag;
  logic [44:0]        da_prod;
  logic [27:0]        s_mag;
  logic signed [26:0] nt;
  logic [26:0]        nt_mag;
  logic [23:0]        ma_mag;
  logic [27:0]        f_num;
  logic [20:0]        f_den;

  function automatic logic [23:0] sat_s24(input logic [47:0] q, input logic neg);
    logic [23:0] res;
    if (neg) begin
      res = (q > 48'd8388608) ? 24'h800000 : 24'((~q) + 48'd1);
    end else begin
      res = (q > 48'd8388607) ? 24'h7FFFFF : q[23:0];
    end
    return res;
  endfunction

  assign win_eff  = (winlen < ctt_pkg::WIN_MIN) ? ctt_pkg::WIN_MIN :
                    (winlen > ctt_pkg::WIN_MAX) ? ctt_pkg::WIN_MAX : winlen;
  assign fill_inc = fill + 5'd1;
  assign ra       = sum_busy ? (slot - 4'd1 - sum_k[3:0]) : (slot - 4'd1);

  // Select divider operands for the issued step
  always_comb begin
    dv      = $signed({1'b0, din}) - $signed({1'b0, rd_d});
    dv_mag  = dv[16] ? 17'(-dv) : 17'(dv);
    dv_prod = 37'(dv_mag) * 37'(ctt_pkg::US_PER_S);
    da      = $signed({vnew[23], vnew}) - $signed({rd_v[23], rd_v});
    da_mag  = da[24] ? 25'(-da) : 25'(da);
    da_prod = 45'(da_mag) * 45'(ctt_pkg::US_PER_S);
    s_mag   = (cmd.op == ctt_pkg::OP_MV) ? (sv[27] ? 28'(-sv) : 28'(sv)) :
                                           (sa[27] ? 28'(-sa) : 28'(sa));
    nt      = -27'(mv) - $signed({3'b000, sqrt_root});
    nt_mag  = nt[26] ? 27'(-nt) : 27'(nt);
    ma_mag  = ma[23] ? 24'(-ma) : 24'(ma);
    f_num   = 28'(md) * 28'(ctt_pkg::FOLLOW_NUM);
    f_den   = 21'(spd) * 21'(ctt_pkg::MPH_TO_FTS);
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_neg   = 1'b0;
    case (cmd.op)
      ctt_pkg::OP_VEL: begin
        div_start = 1'b1;
        div_num   = 48'(dv_prod);
        div_den   = 24'(iv);
        div_neg   = dv[16];
      end
      ctt_pkg::OP_ACC: begin
        div_start = 1'b1;
        div_num   = 48'(da_prod);
        div_den   = 24'(iv);
        div_neg   = da[24];
      end
      ctt_pkg::OP_MD: begin
        div_start = 1'b1;
        div_num   = 48'(sd);
        div_den   = 24'(fill);
      end
      ctt_pkg::OP_MV: begin
        div_start = 1'b1;
        div_num   = 48'(s_mag);
        div_den   = 24'(fill);
        div_neg   = sv[27];
      end
      ctt_pkg::OP_MA: begin
        div_start = 1'b1;
        div_num   = 48'(s_mag);
        div_den   = 24'(fill);
        div_neg   = sa[27];
      end
      ctt_pkg::OP_TTC: begin
        div_start = tt_ok;
        div_num   = 48'({nt_mag, 8'h00});
        div_den   = ma_mag;
        div_neg   = nt[26] ^ ma[23];
      end
      ctt_pkg::OP_FOLLOW: begin
        div_start = (spd != 16'd0);
        div_num   = 48'(f_num);
        div_den   = 24'(f_den);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (cmd.op == ctt_pkg::OP_SQRT) && (ma != 24'sd0) && !disc[48];

  ctt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  ctt_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (disc[47:0]),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  // Rings: write the new entry, read one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.op == ctt_pkg::OP_WRITE) begin
      ring_d[slot] <= din;
      ring_v[slot] <= vnew;
      ring_a[slot] <= anew;
    end
    rd_d <= ring_ok[ra] ? ring_d[ra] : 16'd0;
    rd_v <= ring_ok[ra] ? ring_v[ra] : 24'sd0;
  end

  logic signed [23:0] rd_a;
  always_ff @(posedge clk) begin
    rd_a <= ring_ok[ra] ? ring_a[ra] : 24'sd0;
  end

  // Control state: valid bits, slot, fill, window length, sequencing flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_ok  <= '0;
      slot     <= 4'd2;
      fill     <= 5'd2;
      winlen   <= ctt_pkg::WIN_RESET;
      sum_busy <= 1'b0;
      sum_acc  <= 1'b0;
      sum_k    <= '0;
      div_pend <= 1'b0;
      div_op   <= ctt_pkg::OP_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        winlen <= cfg_wdata;
      end
      if (cmd.op == ctt_pkg::OP_WRITE) begin
        ring_ok[slot] <= 1'b1;
        slot          <= slot + 4'd1;
        fill          <= (fill_inc > win_eff) ? fill : fill_inc;
      end
      // Walk the window newest first
      if (cmd.op == ctt_pkg::OP_SUM) begin
        sum_busy <= 1'b1;
        sum_acc  <= 1'b0;
        sum_k    <= '0;
      end else if (sum_busy) begin
        if (sum_k < fill) begin
          sum_k   <= sum_k + 5'd1;
          sum_acc <= 1'b1;
        end else begin
          sum_acc <= 1'b0;
          if (!sum_acc) begin
            sum_busy <= 1'b0;
          end
        end
      end
      // Track a divide whose quotient is still to be stored
      if (div_start) begin
        div_pend <= 1'b1;
        div_op   <= cmd.op;
      end else if (div_pend && !div_busy) begin
        div_pend <= 1'b0;
      end
      // Output register
      if (cmd.op == ctt_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_neg_r <= div_neg;
    end
    case (cmd.op)
      ctt_pkg::OP_LOAD: begin
        din <= in_data[15:0];
        spd <= in_data[31:16];
        iv  <= (in_data[51:32] == 20'd0) ? 20'd1 : in_data[51:32];
      end
      ctt_pkg::OP_SUM: begin
        sd <= '0;
        sv <= '0;
        sa <= '0;
      end
      ctt_pkg::OP_PROD: begin
        p1 <= mv * mv;
        p2 <= ma * $signed({1'b0, md});
      end
      ctt_pkg::OP_DISC: begin
        disc <= 49'(p1) - (49'(p2) <<< 1);
      end
      ctt_pkg::OP_SQRT: begin
        tt_ok <= (ma != 24'sd0) && !disc[48];
      end
      ctt_pkg::OP_TTC: begin
        if (!tt_ok) begin
          ttc <= '0;
        end
      end
      ctt_pkg::OP_FOLLOW: begin
        if (spd == 16'd0) begin
          ftime <= 16'hFFFF;
        end
      end
      ctt_pkg::OP_OUT: begin
        out_data <= {2'b00, ftime, ttc, ma, mv, md};
      end
      default: begin
      end
    endcase
    // Accumulate the entry read last cycle
    if (sum_busy && sum_acc) begin
      sd <= sd + 20'(rd_d);
      sv <= sv + 28'(rd_v);
      sa <= sa + 28'(rd_a);
    end
    // Store a finished quotient
    if (div_pend && !div_busy) begin
      case (div_op)
        ctt_pkg::OP_VEL: vnew <= sat_s24(div_quo, div_neg_r);
        ctt_pkg::OP_ACC: anew <= sat_s24(div_quo, div_neg_r);
        ctt_pkg::OP_MD:  md   <= div_quo[15:0];
        ctt_pkg::OP_MV:  mv   <= sat_s24(div_quo, div_neg_r);
        ctt_pkg::OP_MA:  ma   <= sat_s24(div_quo, div_neg_r);
        ctt_pkg::OP_TTC: begin
          if ((div_neg_r && div_quo != '0) || div_quo > 48'(ctt_pkg::TTC_MAX)) begin
            ttc <= '0;
          end else begin
            ttc <= div_quo[13:0];
          end
        end
        ctt_pkg::OP_FOLLOW: ftime <= (div_quo > 48'd65535) ? 16'hFFFF : div_quo[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.div_busy  = div_busy || div_pend;
    status.sqrt_busy = sqrt_busy;
    status.sum_busy  = sum_busy;
    status.out_full  = out_valid && !out_ready;
  end

endmodule

>>> design/ctt_ctrl.sv
// Controller: sequences the steps of one sample through the datapath
module ctt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ctt_pkg::status_t status,
  output ctt_pkg::cmd_t    cmd
);

  ctt_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd.op     = ctt_pkg::OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ctt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = ctt_pkg::OP_LOAD;
          state_next = ctt_pkg::S_PREV;
        end
      end
      ctt_pkg::S_PREV: state_next = ctt_pkg::S_VEL;
      ctt_pkg::S_VEL: begin
        cmd.op     = ctt_pkg::OP_VEL;
        state_next = ctt_pkg::S_VEL_W;
      end
      ctt_pkg::S_VEL_W: if (!status.div_busy) state_next = ctt_pkg::S_ACC;
      ctt_pkg::S_ACC: begin
        cmd.op     = ctt_pkg::OP_ACC;
        state_next = ctt_pkg::S_ACC_W;
      end
      ctt_pkg::S_ACC_W: if (!status.div_busy) state_next = ctt_pkg::S_WRITE;
      ctt_pkg::S_WRITE: begin
        cmd.op     = ctt_pkg::OP_WRITE;
        state_next = ctt_pkg::S_SUM;
      end
      ctt_pkg::S_SUM: begin
        cmd.op     = ctt_pkg::OP_SUM;
        state_next = ctt_pkg::S_SUM_W;
      end
      ctt_pkg::S_SUM_W: if (!status.sum_busy) state_next = ctt_pkg::S_MD;
      ctt_pkg::S_MD: begin
        cmd.op     = ctt_pkg::OP_MD;
        state_next = ctt_pkg::S_MD_W;
      end
      ctt_pkg::S_MD_W: if (!status.div_busy) state_next = ctt_pkg::S_MV;
      ctt_pkg::S_MV: begin
        cmd.op     = ctt_pkg::OP_MV;
        state_next = ctt_pkg::S_MV_W;
      end
      ctt_pkg::S_MV_W: if (!status.div_busy) state_next = ctt_pkg::S_MA;
      ctt_pkg::S_MA: begin
        cmd.op     = ctt_pkg::OP_MA;
        state_next = ctt_pkg::S_MA_W;
      end
      ctt_pkg::S_MA_W: if (!status.div_busy) state_next = ctt_pkg::S_PROD;
      ctt_pkg::S_PROD: begin
        cmd.op     = ctt_pkg::OP_PROD;
        state_next = ctt_pkg::S_DISC;
      end
      ctt_pkg::S_DISC: begin
        cmd.op     = ctt_pkg::OP_DISC;
        state_next = ctt_pkg::S_SQRT;
      end
      ctt_pkg::S_SQRT: begin
        cmd.op     = ctt_pkg::OP_SQRT;
        state_next = ctt_pkg::S_SQRT_W;
      end
      ctt_pkg::S_SQRT_W: if (!status.sqrt_busy) state_next = ctt_pkg::S_TTC;
      ctt_pkg::S_TTC: begin
        cmd.op     = ctt_pkg::OP_TTC;
        state_next = ctt_pkg::S_TTC_W;
      end
      ctt_pkg::S_TTC_W: if (!status.div_busy) state_next = ctt_pkg::S_FOL;
      ctt_pkg::S_FOL: begin
        cmd.op     = ctt_pkg::OP_FOLLOW;
        state_next = ctt_pkg::S_FOL_W;
      end
      ctt_pkg::S_FOL_W: if (!status.div_busy) state_next = ctt_pkg::S_OUT;
      ctt_pkg::S_OUT: begin
        if (!status.out_full) begin
          cmd.op     = ctt_pkg::OP_OUT;
          state_next = ctt_pkg::S_IDLE;
        end
      end
      default: state_next = ctt_pkg::S_IDLE;
    endcase
  end

endmodule

>>> design/collision_time_tracker_unit.sv
// Top level of the collision time tracker
//
//  channel   | dir | handshake              | beat content
//  s_axis    | in  | s_axis_tvalid/tready   | distance, speed, interval
//  m_axis    | out | m_axis_tvalid/tready   | means, collision and following time
//  cfg       | in  | cfg_we                 | window length
//
// A sample holds the controller from its accept cycle through its output
// step: seven passes of the shared one-bit-a-cycle divider, a square root
// and a walk over the n entries of the window fill (2 to 16); the root and
// the collision and following divides are skipped when their result is
// invalid.
// rst is synchronous: it empties the window rings to two zero entries and
// sets the window length to 8. A result waits in the output register while
// the next sample is worked; the last step stalls only if it is still held.
module collision_time_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,      // window_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // distance_q8, speed_q8, interval_us, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // mean_distance_q8, mean_velocity_q8,
                                      // mean_accel_q8, collision_time_q8,
                                      // following_time_q8, pad
);

  ctt_pkg::cmd_t    cmd;
  ctt_pkg::status_t status;

  ctt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ctt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

>>> design/ctt_checker.sv
// Port-level assertions for the collision time tracker, bound to the top
`include "collision_time_tracker_unit_defines.svh"

module ctt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // A held result stays until taken
  `CTT_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // One sample at a time: no second accept right after the first
  `CTT_ASSERT_NEXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // Collision time never exceeds sixty seconds
  `CTT_ASSERT_NOW(a_ttc_range, clk, rst, m_axis_tvalid, m_axis_tdata[77:64] <= 14'd15360, "collision time out of range")

  // A new result only follows an accepted sample, not straight after one
  `CTT_ASSERT_NEXT(a_no_fast_out, clk, rst, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result too early")

endmodule

bind collision_time_tracker_unit ctt_checker u_ctt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
